[hdl/tbhd_pkg.sv]
// Package for the table-driven Huffman bit decoder.
// Holds the sizing constants, request and status codes, the small built-in code tables
// and the control and status structs between the top level and the stream unit.
`default_nettype none

package tbhd_pkg;

  localparam int FIFO_DEPTH    = 4;
  localparam int CTRL_ROWS     = 18;
  localparam int DATA_ROWS     = 4;
  localparam int MAX_CODE_BITS = 8;

  // Longest fixed-width read (the raw factor field).
  localparam int FIX_MAX_BITS = 6;
  localparam int NB_MAX       = (MAX_CODE_BITS > FIX_MAX_BITS) ? MAX_CODE_BITS : FIX_MAX_BITS;
  localparam int NB_W         = $clog2(NB_MAX + 1);

  localparam int CTRL_ROW_W = $clog2(CTRL_ROWS);
  localparam int DATA_ROW_W = (DATA_ROWS > 1) ? $clog2(DATA_ROWS) : 1;
  localparam int CTRL_AW    = CTRL_ROW_W + 8;
  localparam int DATA_AW    = DATA_ROW_W + 8;
  localparam int CTRL_DEPTH = CTRL_ROWS * 256;
  localparam int DATA_DEPTH = 256 << DATA_ROW_W;

  // Request actions.
  localparam logic [1:0] ACT_CTRL_WR = 2'd0;
  localparam logic [1:0] ACT_DATA_WR = 2'd1;
  localparam logic [1:0] ACT_PUSH    = 2'd2;
  localparam logic [1:0] ACT_DECODE  = 2'd3;

  // Decode kinds.
  localparam logic [2:0] KIND_FACTOR6 = 3'd0;
  localparam logic [2:0] KIND_CTRL    = 3'd1;
  localparam logic [2:0] KIND_REP     = 3'd2;
  localparam logic [2:0] KIND_DATA    = 3'd3;
  localparam logic [2:0] KIND_INIT5   = 3'd4;

  // Response status.
  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_STARVED = 3'd1;
  localparam logic [2:0] STAT_NOMATCH = 3'd2;
  localparam logic [2:0] STAT_BADTAB  = 3'd3;
  localparam logic [2:0] STAT_FULL    = 3'd4;

  typedef struct packed {
    logic start;
    logic step;
    logic commit;
  } strm_ctl_t;

  typedef struct packed {
    logic bit_val;
    logic avail;
    logic full;
  } strm_sts_t;

  // Built-in data tables two to five, indexed by the one or two code bits read.
  function automatic logic [7:0] small_value(input logic [4:0] tnum, input logic [1:0] code);
    logic [7:0] v;
    v = 8'd0;
    case (tnum)
      5'd2: v = code[0] ? 8'd3 : 8'd253;
      5'd3: begin
        case (code)
          2'd0:    v = 8'd239;
          2'd1:    v = 8'd251;
          2'd2:    v = 8'd5;
          default: v = 8'd17;
        endcase
      end
      5'd4: begin
        case (code)
          2'd0:    v = 8'd249;
          2'd1:    v = 8'd2;
          2'd2:    v = 8'd9;
          default: v = 8'd18;
        endcase
      end
      5'd5: begin
        case (code)
          2'd0:    v = 8'd238;
          2'd1:    v = 8'd247;
          2'd2:    v = 8'd254;
          default: v = 8'd7;
        endcase
      end
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[hdl/tbhd_if.sv]
// Valid/ready channel interfaces of the Huffman bit decoder: request and response.
// Widths are those of the request and response fields; no package dependency.
`default_nettype none

interface tbhd_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [2:0] kind;
  logic [4:0] table_num;
  logic [7:0] table_addr;
  logic [7:0] table_value;
  logic [7:0] stream_byte;

  modport source (output valid, output action, output kind, output table_num,
                  output table_addr, output table_value, output stream_byte, input ready);
  modport sink (input valid, input action, input kind, input table_num,
                input table_addr, input table_value, input stream_byte, output ready);
endinterface

interface tbhd_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic [2:0] status;

  modport source (output valid, output symbol, output status, input ready);
  modport sink (input valid, input symbol, input status, output ready);
endinterface

`default_nettype wire

[hdl/tbhd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Used for the control and data code tables; no package dependency.
`default_nettype none

module tbhd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/tbhd_stream.sv]
// Stream byte FIFO, committed bit buffer and the shared one-bit extraction unit.
// A decode works on a scratch copy of the reader; depends on tbhd_pkg.
`default_nettype none

module tbhd_stream (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push_en,
  input  wire logic [7:0]         push_byte,
  input  wire tbhd_pkg::strm_ctl_t ctl,
  output      tbhd_pkg::strm_sts_t sts
);
  import tbhd_pkg::*;

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int SW = ((PW > CW) ? PW : CW) + 1;

  logic [7:0]    fifo [FIFO_DEPTH];
  logic [PW-1:0] head;
  logic [CW-1:0] count;
  logic [7:0]    bit_buffer;
  logic [3:0]    bits_left;

  // Scratch reader, thrown away when a decode runs dry.
  logic [7:0]    wbuf, wbuf_next;
  logic [3:0]    wleft, wleft_next;
  logic [CW-1:0] wtaken, wtaken_next;

  logic [PW-1:0] rd_idx;
  logic [PW-1:0] wr_idx;
  logic [PW-1:0] head_next;
  logic [7:0]    cur_byte;

  // Circular index; the offset never exceeds the depth, so one subtract is enough.
  function automatic logic [PW-1:0] wrap(input logic [PW-1:0] base, input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(FIFO_DEPTH)) begin
      s = s - SW'(FIFO_DEPTH);
    end
    return s[PW-1:0];
  endfunction

  assign rd_idx    = wrap(head, wtaken);
  assign wr_idx    = wrap(head, count);
  assign cur_byte  = fifo[rd_idx];
  assign head_next = wrap(head, wtaken_next);

  always_comb begin
    wbuf_next   = wbuf;
    wleft_next  = wleft;
    wtaken_next = wtaken;
    if (ctl.start) begin
      wbuf_next   = bit_buffer;
      wleft_next  = bits_left;
      wtaken_next = '0;
    end else if (ctl.step) begin
      if (wleft == 4'd0) begin
        wbuf_next   = {cur_byte[6:0], 1'b0};
        wleft_next  = 4'd7;
        wtaken_next = wtaken + CW'(1);
      end else begin
        wbuf_next  = {wbuf[6:0], 1'b0};
        wleft_next = wleft - 4'd1;
      end
    end
  end

  assign sts.avail   = (wleft != 4'd0) || (wtaken < count);
  assign sts.bit_val = (wleft != 4'd0) ? wbuf[7] : cur_byte[7];
  assign sts.full    = (count == CW'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      count      <= '0;
      bit_buffer <= 8'd0;
      bits_left  <= 4'd0;
      wleft      <= 4'd0;
      wtaken     <= '0;
    end else begin
      wleft  <= wleft_next;
      wtaken <= wtaken_next;
      if (ctl.commit) begin
        head       <= head_next;
        count      <= count - wtaken_next;
        bit_buffer <= wbuf_next;
        bits_left  <= wleft_next;
      end else if (push_en) begin
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    wbuf <= wbuf_next;
    if (push_en) begin
      fifo[wr_idx] <= push_byte;
    end
  end

endmodule

`default_nettype wire

[hdl/table_huffman_bit_decoder.sv]
// Table-driven Huffman bit decoder: one request at a time, one response per request.
// Table writes and stream pushes answer in the cycle after acceptance.
// A fixed-width decode reads its bits one at a time; a Huffman decode does a table
// read and then a length compare for each code bit, and ends with a value read.
// Reset clears the FIFO, the bit buffer and the response; the code tables are not
// cleared and hold nothing useful until written.
`default_nettype none

module table_huffman_bit_decoder (
  input wire logic clk,
  input wire logic rst,
  tbhd_req_if.sink   req,
  tbhd_rsp_if.source rsp
);
  import tbhd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_BIT  = 4'b0010,
    S_LOOK = 4'b0100,
    S_VAL  = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    MD_FIX,
    MD_REP,
    MD_WALK
  } mode_t;

  state_t state, state_next;
  mode_t  mode, mode_next;

  logic [7:0]            acc, acc_next;
  logic [NB_W-1:0]       nbits, nbits_next;
  logic [2:0]            need, need_next;
  logic [2:0]            kind_q;
  logic [4:0]            tnum_q;
  logic                  use_data;
  logic [CTRL_ROW_W-1:0] crow, crow_val;
  logic [DATA_ROW_W-1:0] drow;

  logic       out_valid;
  logic [7:0] out_symbol;
  logic [2:0] out_status;
  logic       out_load;
  logic [7:0] res_symbol;
  logic [2:0] res_status;

  logic accept;
  logic dec_go;
  logic ctrl_we, data_we, push_en;

  strm_ctl_t s_ctl;
  strm_sts_t s_sts;

  logic [5:0] ctrl_sum;
  logic       ctrl_bad;
  logic [4:0] drow_full;
  logic       data_bad;
  logic       small_tab;

  logic [7:0]         acc_bit;
  logic [NB_W-1:0]    nb_inc;
  logic [7:0]         q;
  logic [CTRL_AW-1:0] ctrl_raddr;
  logic [DATA_AW-1:0] data_raddr;
  logic [7:0]         ctrl_q, data_q;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);

  assign rsp.valid  = out_valid;
  assign rsp.symbol = out_symbol;
  assign rsp.status = out_status;

  // Table number checks for the two Huffman kinds.
  assign ctrl_sum  = {1'b0, req.table_num} + 6'd1;
  assign ctrl_bad  = (ctrl_sum >= 6'(CTRL_ROWS));
  assign drow_full = (req.table_num == 5'd0) ? 5'd0 : (req.table_num - 5'd5);
  assign small_tab = (req.table_num inside {[5'd2:5'd5]});
  assign data_bad  = (req.table_num == 5'd1) || (!small_tab && (drow_full >= 5'(DATA_ROWS)));

  assign acc_bit = {acc[6:0], s_sts.bit_val};
  assign nb_inc  = nbits + NB_W'(1);
  assign q       = use_data ? data_q : ctrl_q;

  // Code-length lookup while a bit is taken, value lookup after a match.
  assign ctrl_raddr = (state == S_LOOK) ? {crow_val, acc} : {crow, acc_bit};
  assign data_raddr = (state == S_LOOK) ? {drow, ~acc[7], acc[6:0]} : {drow, acc_bit};

  assign ctrl_we = accept && (req.action == ACT_CTRL_WR) && (req.table_num < 5'(CTRL_ROWS));
  assign data_we = accept && (req.action == ACT_DATA_WR) && (req.table_num < 5'(DATA_ROWS));
  assign push_en = accept && (req.action == ACT_PUSH) && !s_sts.full;

  always_comb begin
    state_next   = state;
    mode_next    = mode;
    acc_next     = acc;
    nbits_next   = nbits;
    need_next    = need;
    dec_go       = 1'b0;
    s_ctl.start  = 1'b0;
    s_ctl.step   = 1'b0;
    s_ctl.commit = 1'b0;
    out_load     = 1'b0;
    res_symbol   = 8'd0;
    res_status   = STAT_OK;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.action)
            ACT_CTRL_WR: begin
              out_load   = 1'b1;
              res_status = (req.table_num < 5'(CTRL_ROWS)) ? STAT_OK : STAT_BADTAB;
            end
            ACT_DATA_WR: begin
              out_load   = 1'b1;
              res_status = (req.table_num < 5'(DATA_ROWS)) ? STAT_OK : STAT_BADTAB;
            end
            ACT_PUSH: begin
              out_load   = 1'b1;
              res_status = s_sts.full ? STAT_FULL : STAT_OK;
            end
            default: begin
              dec_go = 1'b1;
              case (req.kind)
                KIND_FACTOR6: begin
                  mode_next = MD_FIX;
                  need_next = 3'd6;
                end
                KIND_INIT5: begin
                  mode_next = MD_FIX;
                  need_next = 3'd5;
                end
                KIND_REP: begin
                  mode_next = MD_REP;
                  need_next = 3'd2;
                end
                KIND_CTRL: begin
                  mode_next = MD_WALK;
                  need_next = 3'd0;
                  dec_go    = !ctrl_bad;
                end
                KIND_DATA: begin
                  mode_next = small_tab ? MD_FIX : MD_WALK;
                  need_next = (req.table_num == 5'd2) ? 3'd1 : 3'd2;
                  dec_go    = !data_bad;
                end
                default: begin
                  mode_next = MD_FIX;
                  need_next = 3'd0;
                  dec_go    = 1'b0;
                end
              endcase
              if (dec_go) begin
                s_ctl.start = 1'b1;
                acc_next    = 8'd0;
                nbits_next  = '0;
                state_next  = S_BIT;
              end else begin
                out_load   = 1'b1;
                res_status = STAT_BADTAB;
              end
            end
          endcase
        end
      end

      S_BIT: begin
        if (!s_sts.avail) begin
          // The stream ran dry: drop the scratch reader, nothing is consumed.
          out_load   = 1'b1;
          res_status = STAT_STARVED;
          state_next = S_IDLE;
        end else begin
          s_ctl.step = 1'b1;
          acc_next   = acc_bit;
          nbits_next = nb_inc;
          case (mode)
            MD_WALK: state_next = S_LOOK;
            MD_REP: begin
              if (nbits != '0 || !s_sts.bit_val) begin
                s_ctl.commit = 1'b1;
                out_load     = 1'b1;
                if (nbits == '0) begin
                  res_symbol = 8'd0;
                end else begin
                  res_symbol = s_sts.bit_val ? 8'd254 : 8'd2;
                end
                state_next = S_IDLE;
              end
            end
            default: begin
              if (nb_inc == NB_W'(need)) begin
                s_ctl.commit = 1'b1;
                out_load     = 1'b1;
                if (kind_q == KIND_FACTOR6) begin
                  res_symbol = {2'b00, acc_bit[5:0]};
                end else if (kind_q == KIND_INIT5) begin
                  res_symbol = {acc_bit[4:0], 3'b100};
                end else begin
                  res_symbol = small_value(tnum_q, acc_bit[1:0]);
                end
                state_next = S_IDLE;
              end
            end
          endcase
        end
      end

      S_LOOK: begin
        if (q == 8'(nbits)) begin
          state_next = S_VAL;
        end else if (nbits == NB_W'(MAX_CODE_BITS)) begin
          s_ctl.commit = 1'b1;
          out_load     = 1'b1;
          res_status   = STAT_NOMATCH;
          state_next   = S_IDLE;
        end else begin
          state_next = S_BIT;
        end
      end

      S_VAL: begin
        s_ctl.commit = 1'b1;
        out_load     = 1'b1;
        res_symbol   = q;
        state_next   = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode  <= mode_next;
    acc   <= acc_next;
    nbits <= nbits_next;
    need  <= need_next;
    if (out_load) begin
      out_symbol <= res_symbol;
      out_status <= res_status;
    end
    if (dec_go) begin
      kind_q   <= req.kind;
      tnum_q   <= req.table_num;
      use_data <= (req.kind == KIND_DATA);
      crow     <= req.table_num[CTRL_ROW_W-1:0];
      crow_val <= ctrl_sum[CTRL_ROW_W-1:0];
      drow     <= drow_full[DATA_ROW_W-1:0];
    end
  end

  tbhd_stream u_stream (
    .clk       (clk),
    .rst       (rst),
    .push_en   (push_en),
    .push_byte (req.stream_byte),
    .ctl       (s_ctl),
    .sts       (s_sts)
  );

  tbhd_ram #(
    .WIDTH (8),
    .DEPTH (CTRL_DEPTH)
  ) u_ctrl_ram (
    .clk   (clk),
    .we    (ctrl_we),
    .waddr ({req.table_num[CTRL_ROW_W-1:0], req.table_addr}),
    .wdata (req.table_value),
    .raddr (ctrl_raddr),
    .rdata (ctrl_q)
  );

  tbhd_ram #(
    .WIDTH (8),
    .DEPTH (DATA_DEPTH)
  ) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr ({req.table_num[DATA_ROW_W-1:0], req.table_addr}),
    .wdata (req.table_value),
    .raddr (data_raddr),
    .rdata (data_q)
  );

endmodule

`default_nettype wire

[hdl/tbhd_checker.sv]
// Port-level assertions for the Huffman bit decoder, bound to the top level.
// Depends on tbhd_pkg for the action and status codes.
`default_nettype none

module tbhd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       req_valid,
  input wire logic       req_ready,
  input wire logic [1:0] req_action,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic [7:0] rsp_symbol,
  input wire logic [2:0] rsp_status
);
  import tbhd_pkg::*;

  // Table writes and pushes are answered in the very next cycle.
  a_quick_rsp: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_action != ACT_DECODE) |=> rsp_valid)
    else $error("table write or push not answered in the next cycle");

  // A push can only succeed or report a full FIFO.
  a_push_status: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_action == ACT_PUSH) |=>
      (rsp_status == STAT_OK || rsp_status == STAT_FULL))
    else $error("push request answered with an unexpected status");

  // Any error response carries a zero symbol.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status != STAT_OK) |-> (rsp_symbol == 8'd0))
    else $error("error response with a non-zero symbol");

  // A response held back keeps its contents.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_symbol) && $stable(rsp_status)))
    else $error("stalled response changed or vanished");

  a_rst_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid straight after reset");

endmodule

bind table_huffman_bit_decoder tbhd_checker u_tbhd_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .req_action (req.action),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_symbol (rsp.symbol),
  .rsp_status (rsp.status)
);

`default_nettype wire

[bench/tb_table_huffman_bit_decoder.sv]
// Self-checking bench for the table-driven Huffman bit decoder.
// Needs tbhd_pkg and the channel interfaces; every response is predicted by a
// model of the decoder kept in this file and compared in arrival order.
module tb_table_huffman_bit_decoder;
  import tbhd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned QUIET_FROM  = 3000;
  localparam int unsigned QUIET_TO    = 7000;
  localparam int unsigned RANDOM_ITEMS = 850;
  localparam logic [2:0]  KIND_UNUSED = 3'd7;
  // A forced code length that no walk can reach, so the walk runs out of bits.
  localparam int unsigned NEVER_LEN = MAX_CODE_BITS + 1;

  // Built-in data tables two to five, indexed [table - 2][code].
  localparam logic [3:0][3:0][7:0] BUILTIN = {
    {8'd7,  8'd254, 8'd247, 8'd238},
    {8'd18, 8'd9,   8'd2,   8'd249},
    {8'd17, 8'd5,   8'd251, 8'd239},
    {8'd3,  8'd253, 8'd3,   8'd253}
  };

  typedef struct {
    logic [1:0] action;
    logic [2:0] kind;
    logic [4:0] table_num;
    logic [7:0] table_addr;
    logic [7:0] table_value;
    logic [7:0] stream_byte;
    bit         hold;
    logic [7:0] want_symbol;
    logic [2:0] want_status;
  } request_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic [2:0] status;
  } outcome_t;

  logic clk;
  logic rst;

  tbhd_req_if req_ch ();
  tbhd_rsp_if rsp_ch ();

  table_huffman_bit_decoder dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  request_t    request_q [$];
  outcome_t    outcome_q [$];
  request_t    cur_req;
  int unsigned cycles;
  int unsigned fail_count;

  // Decoder image: tables with a written flag per entry, FIFO and bit buffer.
  logic [7:0]  ctrl_img [CTRL_ROWS*256];
  bit          ctrl_known [CTRL_ROWS*256];
  logic [7:0]  data_img [DATA_ROWS*256];
  bit          data_known [DATA_ROWS*256];
  logic [7:0]  fifo_img [FIFO_DEPTH];
  int unsigned fifo_fill;
  logic [7:0]  shift_reg;
  int unsigned shift_left;

  // Trial read position, so that a starved decode leaves the image untouched.
  logic [7:0]  rd_buf;
  int unsigned rd_left;
  int unsigned rd_taken;

  // First table entry a decode would read before it has been written.
  bit          gap_hit;
  bit          gap_in_data;
  int unsigned gap_idx;
  int unsigned gap_len;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  function automatic bit idle_roll();
    if (cycles >= QUIET_FROM && cycles < QUIET_TO) return 1'b0;
    return $urandom_range(99) < 10;
  endfunction

  function automatic int pull_bit();
    int b;
    if (rd_left == 0) begin
      if (rd_taken >= fifo_fill || rd_taken >= FIFO_DEPTH) return -1;
      rd_buf = fifo_img[rd_taken];
      rd_taken++;
      rd_left = 8;
    end
    b = rd_buf[7];
    rd_buf = rd_buf << 1;
    rd_left--;
    return b;
  endfunction

  function automatic logic [7:0] tab_lookup(bit in_data, int unsigned idx, int unsigned len);
    bit known;
    known = in_data ? data_known[idx] : ctrl_known[idx];
    if (!known) begin
      if (!gap_hit) begin
        gap_hit = 1'b1;
        gap_in_data = in_data;
        gap_idx = idx;
        gap_len = len;
      end
      return 8'd0;
    end
    return in_data ? data_img[idx] : ctrl_img[idx];
  endfunction

  function automatic logic [2:0] take_bits(int unsigned n, output logic [7:0] v);
    int b;
    logic [7:0] acc;
    acc = 8'd0;
    for (int i = 0; i < n; i++) begin
      b = pull_bit();
      if (b < 0) return STAT_STARVED;
      acc = {acc[6:0], b[0]};
    end
    v = acc;
    return STAT_OK;
  endfunction

  // A code of n bits matches when the length row holds n at its numeric value.
  function automatic logic [2:0] walk_lengths(bit in_data, int unsigned base,
                                              output logic [7:0] code);
    int b;
    logic [7:0] acc;
    acc = 8'd0;
    code = 8'd0;
    for (int n = 1; n <= MAX_CODE_BITS; n++) begin
      b = pull_bit();
      if (b < 0) return STAT_STARVED;
      acc = {acc[6:0], b[0]};
      if (tab_lookup(in_data, base + acc, n) == 8'(n)) begin
        code = acc;
        return STAT_OK;
      end
    end
    return STAT_NOMATCH;
  endfunction

  function automatic void run_decode(input logic [2:0] kind, input logic [4:0] tnum,
                                     output logic [7:0] sym, output logic [2:0] st);
    logic [7:0]  v;
    int unsigned t;
    int unsigned row;
    t = tnum;
    v = 8'd0;
    sym = 8'd0;
    st = STAT_OK;
    gap_hit = 1'b0;
    rd_buf = shift_reg;
    rd_left = shift_left;
    rd_taken = 0;
    case (kind)
      KIND_FACTOR6: st = take_bits(6, v);
      KIND_INIT5: begin
        st = take_bits(5, v);
        v = {v[4:0], 3'b100};
      end
      KIND_REP: begin
        st = take_bits(1, v);
        if (st == STAT_OK && v[0]) begin
          st = take_bits(1, v);
          v = v[0] ? 8'd254 : 8'd2;
        end
      end
      KIND_CTRL: begin
        if (t + 1 >= CTRL_ROWS) begin
          st = STAT_BADTAB;
        end else begin
          st = walk_lengths(1'b0, t * 256, v);
          if (st == STAT_OK) v = tab_lookup(1'b0, (t + 1) * 256 + v, 0);
        end
      end
      KIND_DATA: begin
        row = (t == 0) ? 0 : t - 5;
        if (t == 1) begin
          st = STAT_BADTAB;
        end else if (t >= 2 && t <= 5) begin
          st = take_bits((t == 2) ? 1 : 2, v);
          v = BUILTIN[t - 2][v[1:0]];
        end else if (row >= DATA_ROWS) begin
          st = STAT_BADTAB;
        end else begin
          st = walk_lengths(1'b1, row * 256, v);
          // Values sit in the upper half: adding 128 modulo 256 flips the top bit.
          if (st == STAT_OK) v = tab_lookup(1'b1, row * 256 + {~v[7], v[6:0]}, 0);
        end
      end
      default: st = STAT_BADTAB;
    endcase
    if (!gap_hit && (st == STAT_OK || st == STAT_NOMATCH)) begin
      for (int i = 0; i < FIFO_DEPTH; i++)
        fifo_img[i] = (i + rd_taken < FIFO_DEPTH) ? fifo_img[i + rd_taken] : 8'h00;
      fifo_fill = fifo_fill - rd_taken;
      shift_reg = rd_buf;
      shift_left = rd_left;
      if (st == STAT_OK) sym = v;
    end
  endfunction

  // Fields that the action does not use still carry random bits.
  function automatic request_t blank_request(logic [1:0] act);
    request_t r;
    r.action = act;
    r.kind = 3'($urandom_range(7));
    r.table_num = 5'($urandom_range(31));
    r.table_addr = 8'($urandom_range(255));
    r.table_value = 8'($urandom_range(255));
    r.stream_byte = 8'($urandom_range(255));
    r.hold = 1'b0;
    r.want_symbol = 8'd0;
    r.want_status = STAT_OK;
    return r;
  endfunction

  task automatic enqueue(request_t r);
    r.hold = (request_q.size() == 300 || request_q.size() == 700);
    request_q.push_back(r);
  endtask

  task automatic gen_write(bit in_data, int unsigned row, logic [7:0] addr, logic [7:0] value);
    request_t r;
    r = blank_request(in_data ? ACT_DATA_WR : ACT_CTRL_WR);
    r.table_num = 5'(row);
    r.table_addr = addr;
    r.table_value = value;
    if (in_data && row < DATA_ROWS) begin
      data_img[row * 256 + addr] = value;
      data_known[row * 256 + addr] = 1'b1;
    end else if (!in_data && row < CTRL_ROWS) begin
      ctrl_img[row * 256 + addr] = value;
      ctrl_known[row * 256 + addr] = 1'b1;
    end else begin
      r.want_status = STAT_BADTAB;
    end
    enqueue(r);
  endtask

  task automatic gen_push(logic [7:0] value);
    request_t r;
    r = blank_request(ACT_PUSH);
    r.stream_byte = value;
    if (fifo_fill < FIFO_DEPTH) begin
      fifo_img[fifo_fill] = value;
      fifo_fill++;
    end else begin
      r.want_status = STAT_FULL;
    end
    enqueue(r);
  endtask

  // Any entry the decode would read unwritten is loaded first. A length entry
  // matches its code length with probability pct, or only at force_len if given.
  task automatic gen_decode(logic [2:0] kind, logic [4:0] tnum, int unsigned pct,
                            int unsigned force_len);
    request_t   r;
    logic [7:0] sym;
    logic [2:0] st;
    logic [7:0] fill;
    run_decode(kind, tnum, sym, st);
    while (gap_hit) begin
      if (gap_len == 0) begin
        fill = 8'($urandom_range(255));
      end else if (force_len != 0 ? gap_len == force_len : $urandom_range(99) < pct) begin
        fill = 8'(gap_len);
      end else begin
        fill = 8'($urandom_range(255));
        if (fill == gap_len) fill = 8'd0;
      end
      gen_write(gap_in_data, gap_idx / 256, 8'(gap_idx % 256), fill);
      run_decode(kind, tnum, sym, st);
    end
    r = blank_request(ACT_DECODE);
    r.kind = kind;
    r.table_num = tnum;
    r.want_symbol = sym;
    r.want_status = st;
    enqueue(r);
  endtask

  // Request driver: a held request stays on the channel until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        outcome_q.push_back({cur_req.want_symbol, cur_req.want_status});
      if (!req_ch.valid || req_ch.ready) begin
        if (request_q.size() != 0 && !(request_q[0].hold && outcome_q.size() != 0) &&
            !idle_roll()) begin
          cur_req = request_q.pop_front();
          req_ch.valid       <= 1'b1;
          req_ch.action      <= cur_req.action;
          req_ch.kind        <= cur_req.kind;
          req_ch.table_num   <= cur_req.table_num;
          req_ch.table_addr  <= cur_req.table_addr;
          req_ch.table_value <= cur_req.table_value;
          req_ch.stream_byte <= cur_req.stream_byte;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor.
  always @(posedge clk) begin : monitor
    outcome_t oldest;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (outcome_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected response: symbol %0d status %0d",
                     rsp_ch.symbol, rsp_ch.status);
        end else begin
          oldest = outcome_q.pop_front();
          if (rsp_ch.symbol !== oldest.symbol || rsp_ch.status !== oldest.status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: symbol expected %0d got %0d, status expected %0d got %0d",
                       oldest.symbol, rsp_ch.symbol, oldest.status, rsp_ch.status);
          end
        end
      end
      rsp_ch.ready <= !idle_roll();
    end
  end

  initial begin : stimulus
    int unsigned random_goal;
    int unsigned roll;
    int unsigned pick;
    int unsigned t;
    rst = 1'b1;
    fail_count = 0;
    req_ch.valid = 1'b0;
    req_ch.action = ACT_PUSH;
    req_ch.kind = KIND_FACTOR6;
    req_ch.table_num = 5'd0;
    req_ch.table_addr = 8'd0;
    req_ch.table_value = 8'd0;
    req_ch.stream_byte = 8'd0;
    rsp_ch.ready = 1'b0;
    fifo_fill = 0;
    shift_reg = 8'd0;
    shift_left = 0;

    // Directed part: starved decode, a full FIFO, every fixed kind, bad tables.
    gen_decode(KIND_FACTOR6, 5'd0, 0, 0);
    gen_push(8'hFF);
    gen_push(8'h00);
    gen_push(8'hA5);
    gen_push(8'h5A);
    gen_push(8'h33);
    gen_decode(KIND_FACTOR6, 5'd0, 0, 0);
    gen_decode(KIND_REP, 5'd0, 0, 0);
    gen_decode(KIND_REP, 5'd0, 0, 0);
    gen_decode(KIND_INIT5, 5'd0, 0, 0);
    gen_decode(KIND_DATA, 5'd2, 0, 0);
    gen_decode(KIND_DATA, 5'd3, 0, 0);
    gen_decode(KIND_DATA, 5'd4, 0, 0);
    gen_decode(KIND_DATA, 5'd5, 0, 0);
    gen_decode(KIND_REP, 5'd0, 0, 0);
    gen_decode(KIND_UNUSED, 5'd0, 0, 0);
    gen_decode(KIND_CTRL, 5'd17, 0, 0);
    gen_decode(KIND_DATA, 5'd1, 0, 0);
    gen_decode(KIND_DATA, 5'd31, 0, 0);
    gen_write(1'b0, 31, 8'hFF, 8'hFF);
    gen_write(1'b1, 4, 8'h00, 8'h00);
    gen_push(8'hFF);
    gen_push(8'hFF);
    // A control walk that never matches, then an eight-bit data code of all
    // ones whose value index wraps round the row, then a one-bit control code.
    gen_decode(KIND_CTRL, 5'd3, 0, NEVER_LEN);
    gen_decode(KIND_FACTOR6, 5'd0, 0, 0);
    gen_decode(KIND_DATA, 5'd8, 0, MAX_CODE_BITS);
    gen_decode(KIND_CTRL, 5'd0, 0, 1);

    // Random part: mostly a well-fed stream and decodable requests.
    random_goal = request_q.size() + RANDOM_ITEMS;
    while (request_q.size() < random_goal) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        gen_write(1'b0, ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(17),
                  8'($urandom_range(255)),
                  8'($urandom_range(1) ? $urandom_range(8) : $urandom_range(255)));
      end else if (roll < 6) begin
        gen_write(1'b1, ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(3),
                  8'($urandom_range(255)),
                  8'($urandom_range(1) ? $urandom_range(8) : $urandom_range(255)));
      end else if (roll < 10 ||
                   (fifo_fill < FIFO_DEPTH && roll < ((fifo_fill < 2) ? 60 : 35))) begin
        gen_push(8'($urandom_range(255)));
      end else begin
        pick = $urandom_range(99);
        case ($urandom_range(2))
          0:       roll = 15;
          1:       roll = 45;
          default: roll = 80;
        endcase
        if (pick < 12) begin
          gen_decode(KIND_FACTOR6, 5'($urandom_range(31)), roll, 0);
        end else if (pick < 24) begin
          gen_decode(KIND_INIT5, 5'($urandom_range(31)), roll, 0);
        end else if (pick < 36) begin
          gen_decode(KIND_REP, 5'($urandom_range(31)), roll, 0);
        end else if (pick < 66) begin
          t = ($urandom_range(19) == 0) ? $urandom_range(31, 17) : $urandom_range(16);
          gen_decode(KIND_CTRL, 5'(t), roll, 0);
        end else if (pick < 96) begin
          if ($urandom_range(19) == 0) begin
            t = $urandom_range(1) ? 1 : $urandom_range(31, 9);
          end else begin
            t = $urandom_range(7);
            if (t == 1) t = 8;
          end
          gen_decode(KIND_DATA, 5'(t), roll, 0);
        end else begin
          gen_decode(3'($urandom_range(7, 5)), 5'($urandom_range(31)), roll, 0);
        end
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (request_q.size() != 0 || req_ch.valid) @(posedge clk);
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

[sim.f]
hdl/tbhd_pkg.sv
hdl/tbhd_if.sv
hdl/tbhd_ram.sv
hdl/tbhd_stream.sv
hdl/table_huffman_bit_decoder.sv
hdl/tbhd_checker.sv
bench/tb_table_huffman_bit_decoder.sv
